// ===== rtl/core/rgbxyb_pkg.sv =====
// Package for the sRGB to XYB quantizer: constants, mixing coefficients,
// the linearization table generator and the quantizer helper.
// No dependencies.
package rgbxyb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CBRT_STEPS    = 21;
  localparam int PIX_W         = 8;
  localparam int COEF_W        = 30;
  localparam int MIX_W         = 64;
  localparam int ROOT_W        = 21;
  localparam int REM_W         = 50;
  localparam int Q_W           = 40;

  localparam logic [22:0] BIAS_Q30      = 23'd4072781;
  localparam logic [22:0] CBRT_BIAS_Q20 = 23'd163530;

  typedef logic [COEF_W-1:0] coef_t;

  function automatic coef_t mix_coef(input int k, input int i);
    coef_t c;
    c = '0;
    case (k * 3 + i)
      0:       c = 30'd322122547;
      1:       c = 30'd667867415;
      2:       c = 30'd83751862;
      3:       c = 30'd246960620;
      4:       c = 30'd743029342;
      5:       c = 30'd83751862;
      6:       c = 30'd261373122;
      7:       c = 30'd219867369;
      8:       c = 30'd592501333;
      default: c = '0;
    endcase
    return c;
  endfunction

  // sRGB curve entry in Q(frac); evaluated at elaboration only.
  function automatic logic [63:0] lin_entry(input int v, input int frac);
    logic [63:0] e, t, s, z, c, c2, c4, c5, y, vv;
    e  = '0;
    vv = 64'(v);
    if (v <= 10) begin
      e = (((vv * 64'd5) << frac) + 64'd8236) / 64'd16473;
    end else if (v == 255) begin
      e = 64'd1 << frac;
    end else begin
      t = (((vv * 64'd1000 + 64'd14025) << 32) + 64'd134512) / 64'd269025;
      s = (t * t) >> 32;
      z = '0;
      for (int b = 31; b >= 0; b--) begin
        c  = z | (64'd1 << b);
        c2 = (c * c) >> 32;
        c4 = (c2 * c2) >> 32;
        c5 = (c4 * c) >> 32;
        if (c5 <= s) z = c;
      end
      y = (s * z) >> 32;
      e = (y + (64'd1 << (31 - frac))) >> (32 - frac);
    end
    return e;
  endfunction

  // Q21 value times nothing more: truncate toward zero, then clamp.
  function automatic logic [7:0] quant(input logic signed [Q_W-1:0] q,
                                       input logic signed [Q_W-1:0] lo,
                                       input logic signed [Q_W-1:0] hi);
    logic signed [Q_W-1:0] t;
    t = (q >= 0) ? (q >>> 21) : -((-q) >>> 21);
    if (t < lo) t = lo;
    else if (t > hi) t = hi;
    return t[7:0];
  endfunction

endpackage

// ===== rtl/core/rgbxyb_if.sv =====
// Channel interfaces for the sRGB to XYB quantizer: pixel in, XYB word out.
// Depends on nothing.
interface rgbxyb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbxyb_xyb_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_chroma;
  logic [7:0] y_luma;
  logic [7:0] b_blue;
  modport source (output valid, x_chroma, y_luma, b_blue, input ready);
  modport sink   (input valid, x_chroma, y_luma, b_blue, output ready);
endinterface

// ===== rtl/core/rgbxyb_cbrt.sv =====
// Pipelined integer cube root, one result bit per stage (restoring digit
// recurrence, no multipliers). Depends on rgbxyb_pkg.
module rgbxyb_cbrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rgbxyb_pkg::MIX_W-1:0]      m,
  output logic [rgbxyb_pkg::ROOT_W-1:0]     root
);
  import rgbxyb_pkg::*;

  logic [MIX_W-1:0]    m_r   [0:CBRT_STEPS-1];
  logic [REM_W-1:0]    rem_r [0:CBRT_STEPS-1];
  logic [ROOT_W-1:0]   y_r   [0:CBRT_STEPS-1];
  logic [2*ROOT_W-1:0] ysq_r [0:CBRT_STEPS-1];

  for (genvar j = 0; j < CBRT_STEPS; j++) begin : g_step
    localparam int SH = 3 * (CBRT_STEPS - 1 - j);
    logic [MIX_W-1:0]    m_in;
    logic [REM_W-1:0]    rem_in, rem_sh, trial, rem_nxt;
    logic [ROOT_W-1:0]   y_in, y_nxt;
    logic [2*ROOT_W-1:0] ysq_in, ysq_nxt;

    if (j == 0) begin : g_first
      assign m_in   = m;
      assign rem_in = '0;
      assign y_in   = '0;
      assign ysq_in = '0;
    end else begin : g_next
      assign m_in   = m_r[j-1];
      assign rem_in = rem_r[j-1];
      assign y_in   = y_r[j-1];
      assign ysq_in = ysq_r[j-1];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-4:0], m_in[SH+2 -: 3]};
      // (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
      trial  = (REM_W'(ysq_in) << 3) + (REM_W'(ysq_in) << 2)
             + (REM_W'(y_in) << 2) + (REM_W'(y_in) << 1) + REM_W'(1);
      if (rem_sh >= trial) begin
        rem_nxt = rem_sh - trial;
        y_nxt   = {y_in[ROOT_W-2:0], 1'b1};
        ysq_nxt = (ysq_in << 2) + ((2*ROOT_W)'(y_in) << 2) + (2*ROOT_W)'(1);
      end else begin
        rem_nxt = rem_sh;
        y_nxt   = {y_in[ROOT_W-2:0], 1'b0};
        ysq_nxt = ysq_in << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j]   <= m_in;
        rem_r[j] <= rem_nxt;
        y_r[j]   <= y_nxt;
        ysq_r[j] <= ysq_nxt;
      end
    end
  end

  assign root = y_r[CBRT_STEPS-1];

endmodule

// ===== rtl/core/rgb_to_xyb_quantizer.sv =====
// Top level of the sRGB to XYB quantizer: table lookup, LMS mix, cube roots
// and quantization. Depends on rgbxyb_pkg, rgbxyb_if and rgbxyb_cbrt.
//
//   channel  | direction | word
//   in_px    | sink      | red, green, blue (8-bit sRGB codes)
//   out_px   | source    | x_chroma, y_luma, b_blue (8-bit XYB codes)
//
// One pixel is accepted every clock unless the output word is held. Stages in
// order: table read, multiply, sum, 21 cube-root digit stages, quantize to
// the output register. The 21-stage root pipeline sets the depth. Reset
// (rst_n, synchronous) clears all valid bits. When the output word is held by
// the sink, every stage freezes together, so nothing is dropped or repeated.
module rgb_to_xyb_quantizer #(
  parameter int FRAC_BITS = rgbxyb_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  rgbxyb_pix_if.sink         in_px,
  rgbxyb_xyb_if.source       out_px
);
  import rgbxyb_pkg::*;

  localparam int LIN_W  = FRAC_BITS + 1;
  localparam int PROD_W = LIN_W + COEF_W;
  localparam int NVLD   = 3 + CBRT_STEPS;

  // Constant linearization table, one entry per code.
  logic [LIN_W-1:0] lin_tbl [0:255];
  for (genvar v = 0; v < 256; v++) begin : g_tbl
    localparam logic [63:0] ENTRY = lin_entry(v, FRAC_BITS);
    assign lin_tbl[v] = ENTRY[LIN_W-1:0];
  end

  // Whole pipeline advances together unless the output word is stuck.
  logic en;
  assign en          = !out_px.valid || out_px.ready;
  assign in_px.ready = en;

  logic [NVLD-1:0] vld_r, vld_nxt;
  logic            out_vld_r;

  always_comb begin
    vld_nxt = {vld_r[NVLD-2:0], in_px.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= vld_nxt;
      out_vld_r <= vld_r[NVLD-1];
    end
  end

  // Stage 1: table lookup.
  logic [LIN_W-1:0] lin_r [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      lin_r[0] <= lin_tbl[in_px.red];
      lin_r[1] <= lin_tbl[in_px.green];
      lin_r[2] <= lin_tbl[in_px.blue];
    end
  end

  // Stage 2: nine coefficient products. Stage 3: sum plus bias, to Q60.
  logic [PROD_W-1:0] prod_r [0:2][0:2];
  logic [MIX_W-1:0]  mix_r  [0:2];
  logic [MIX_W-1:0]  mix_nxt [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod_r[k][i] <= PROD_W'(lin_r[i]) * PROD_W'(mix_coef(k, i));
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix_nxt[k] = ((MIX_W'(BIAS_Q30) << FRAC_BITS) + MIX_W'(prod_r[k][0])
                  + MIX_W'(prod_r[k][1]) + MIX_W'(prod_r[k][2])) << (30 - FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) mix_r[k] <= mix_nxt[k];
    end
  end

  // Cube roots of L, M and S.
  logic [ROOT_W-1:0] root [0:2];
  for (genvar k = 0; k < 3; k++) begin : g_root
    rgbxyb_cbrt u_cbrt (
      .clk  (clk),
      .en   (en),
      .m    (mix_r[k]),
      .root (root[k])
    );
  end

  // Quantize: X = (L-M)/2, Y = (L+M)/2 + 128/255, B = S, all scaled by 255.
  logic signed [Q_W-1:0] g0, g1, g2, dq, sq, bq;
  logic [7:0] x_nxt, y_nxt, b_nxt;
  logic [7:0] x_r, y_r, b_r;

  always_comb begin
    g0    = Q_W'(signed'({1'b0, root[0]})) - Q_W'(signed'({1'b0, CBRT_BIAS_Q20}));
    g1    = Q_W'(signed'({1'b0, root[1]})) - Q_W'(signed'({1'b0, CBRT_BIAS_Q20}));
    g2    = Q_W'(signed'({1'b0, root[2]})) - Q_W'(signed'({1'b0, CBRT_BIAS_Q20}));
    dq    = ((g0 - g1) <<< 8) - (g0 - g1);
    sq    = ((g0 + g1) <<< 8) - (g0 + g1) + (Q_W'(128) <<< 21);
    bq    = (g2 <<< 9) - (g2 <<< 1);
    x_nxt = quant(dq, -Q_W'(128), Q_W'(127));
    y_nxt = quant(sq, Q_W'(0), Q_W'(255));
    b_nxt = quant(bq, -Q_W'(128), Q_W'(127));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      b_r <= b_nxt;
    end
  end

  assign out_px.valid    = out_vld_r;
  assign out_px.x_chroma = x_r;
  assign out_px.y_luma   = y_r;
  assign out_px.b_blue   = b_r;

endmodule

// ===== dv/rgbxyb_checker.sv =====
// Checker for the sRGB to XYB quantizer: predicts each XYB word from the
// accepted pixels and compares. Depends on rgbxyb_pkg and rgbxyb_if.
`timescale 1ns / 1ps
module rgbxyb_checker (
  input  logic         clk,
  input  logic         rst_n,
  rgbxyb_pix_if        pix,
  rgbxyb_xyb_if        xyb,
  output int           fail_count,
  output int           pending,
  output int           word_count
);
  import rgbxyb_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    logic [7:0] x_chroma;
    logic [7:0] y_luma;
    logic [7:0] b_blue;
  } xyb_word_t;

  logic [31:0] srgb_lin [256];
  xyb_word_t   xyb_due [$];

  function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 32;
  endfunction

  // Fills the linear-light table with the integer sRGB curve.
  task automatic fill_srgb_table();
    logic [63:0] ent, t, sq, z, c, c2, c5, v64;
    for (int v = 0; v < 256; v++) begin
      v64 = 64'(v);
      if (v <= 10) begin
        ent = (((v64 * 64'd5) << FRAC) + 64'd8236) / 64'd16473;
      end else if (v == 255) begin
        ent = 64'd1 << FRAC;
      end else begin
        t  = (((v64 * 64'd1000 + 64'd14025) << 32) + 64'd134512) / 64'd269025;
        sq = q32_mul(t, t);
        z  = '0;
        for (int b = 31; b >= 0; b--) begin
          c  = z | (64'd1 << b);
          c2 = q32_mul(c, c);
          c5 = q32_mul(q32_mul(c2, c2), c);
          if (c5 <= sq) z = c;
        end
        ent = (q32_mul(sq, z) + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
      end
      srgb_lin[v] = ent[31:0];
    end
  endtask

  function automatic logic [7:0] trunc_clamp(input longint q, input longint lo,
                                             input longint hi);
    longint t;
    t = (q >= 0) ? (q >>> 21) : -((-q) >>> 21);
    if (t < lo) t = lo;
    else if (t > hi) t = hi;
    return t[7:0];
  endfunction

  function automatic xyb_word_t xyb_of_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [63:0] lin [3];
    logic [63:0] mix, root, cand;
    longint      opp [3];
    longint      diff, sum;
    xyb_word_t   w;
    lin[0] = 64'(srgb_lin[r]);
    lin[1] = 64'(srgb_lin[g]);
    lin[2] = 64'(srgb_lin[b]);
    for (int k = 0; k < 3; k++) begin
      mix = 64'(BIAS_Q30) << FRAC;
      for (int i = 0; i < 3; i++) mix += lin[i] * 64'(mix_coef(k, i));
      mix = mix << (30 - FRAC);
      root = '0;
      for (int s = CBRT_STEPS - 1; s >= 0; s--) begin
        cand = root | (64'd1 << s);
        if (cand * cand * cand <= mix) root = cand;
      end
      opp[k] = longint'(root) - longint'(CBRT_BIAS_Q20);
    end
    diff = opp[0] - opp[1];
    sum  = opp[0] + opp[1];
    w.x_chroma = trunc_clamp(diff * 255, -128, 127);
    w.y_luma   = trunc_clamp(sum * 255 + (longint'(128) << 21), 0, 255);
    w.b_blue   = trunc_clamp(opp[2] * 510, -128, 127);
    return w;
  endfunction

  initial begin
    fill_srgb_table();
    fail_count = 0;
    word_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    xyb_word_t want, got;
    if (rst_n) begin
      if (pix.valid && pix.ready)
        xyb_due.push_back(xyb_of_pixel(pix.red, pix.green, pix.blue));
      if (xyb.valid && xyb.ready) begin
        got = {xyb.x_chroma, xyb.y_luma, xyb.b_blue};
        word_count++;
        if (xyb_due.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d b=%0d", $time,
                   $signed(got.x_chroma), got.y_luma, $signed(got.b_blue));
          fail_count++;
        end else begin
          want = xyb_due.pop_front();
          if (got.x_chroma !== want.x_chroma) begin
            $display("%0t: x_chroma expected %0d actual %0d", $time,
                     $signed(want.x_chroma), $signed(got.x_chroma));
            fail_count++;
          end
          if (got.y_luma !== want.y_luma) begin
            $display("%0t: y_luma expected %0d actual %0d", $time,
                     want.y_luma, got.y_luma);
            fail_count++;
          end
          if (got.b_blue !== want.b_blue) begin
            $display("%0t: b_blue expected %0d actual %0d", $time,
                     $signed(want.b_blue), $signed(got.b_blue));
            fail_count++;
          end
        end
      end
    end
    pending = xyb_due.size();
  end
endmodule

// ===== dv/testbench.sv =====
// Top of the quantizer testbench: clock, reset, pixel stimulus, output
// back-pressure and the verdict. Depends on rgbxyb_if, rgbxyb_checker and rgb_to_xyb_quantizer.
`timescale 1ns / 1ps
module testbench;
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rgbxyb_pix_if in_px();
  rgbxyb_xyb_if out_px();

  int fail_count, pending, word_count;

  // Set by the stimulus: quiet turns idling off for the final stretch,
  // hold_req asks the receiver for one long hold-off.
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  localparam int WATCHDOG = 4000;
  localparam int LONG_HOLD = 80;
  localparam int RANDOM_PIXELS = 2000;

  rgb_to_xyb_quantizer dut (.clk(clk), .rst_n(rst_n), .in_px(in_px), .out_px(out_px));

  rgbxyb_checker chk (.clk(clk), .rst_n(rst_n), .pix(in_px), .xyb(out_px),
                      .fail_count(fail_count), .pending(pending),
                      .word_count(word_count));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_px.valid = 1'b0;
    in_px.red = '0;
    in_px.green = '0;
    in_px.blue = '0;
    out_px.ready = 1'b0;
  end

  // Offers one pixel word and returns at the edge where it was taken. A
  // random gap may come first unless the run is quiet.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (!quiet && ($urandom_range(0, 3) == 0)) begin
      in_px.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_px.valid <= 1'b1;
    in_px.red   <= r;
    in_px.green <= g;
    in_px.blue  <= b;
    @(posedge clk);
    while (!in_px.ready) @(posedge clk);
  endtask

  // Picks a channel code, leaning toward the ends of the range and the
  // point where the curve switches from linear to the power law.
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 7))
      0:       return 8'($urandom_range(0, 12));
      1:       return 8'($urandom_range(250, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: random ready drops, one long hold-off
  // when asked, and steady ready once the run is quiet.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_px.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_px.ready <= 1'b1;
        @(posedge clk);
      end else if (!quiet && ($urandom_range(0, 3) == 0)) begin
        out_px.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_px.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_px.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: too many cycles in a row with no word moving on either side.
  always @(posedge clk) begin
    if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready))
      idle_cycles <= 0;
    else if (rst_n)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired with %0d words outstanding", $time, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [7:0] corner [6];
    corner = '{8'd0, 8'd10, 8'd11, 8'd128, 8'd254, 8'd255};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: black, white, primaries, secondaries, and codes on both
    // sides of the end of the linear segment of the curve.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    for (int i = 0; i < 6; i++) send_pixel(corner[i], corner[i], corner[i]);
    send_pixel(8'd10, 8'd11, 8'd254);
    send_pixel(8'd11, 8'd254, 8'd10);
    send_pixel(8'd254, 8'd10, 8'd11);
    send_pixel(8'd1, 8'd0, 8'd255);
    send_pixel(8'd85, 8'd170, 8'd51);

    // Sender pause: let the pipeline drain completely before going random.
    in_px.valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n == 500) hold_req = 1'b1;
      if (n == RANDOM_PIXELS - 300) quiet = 1'b1;
      send_pixel(pick_code(), pick_code(), pick_code());
    end
    in_px.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d XYB words from %0d directed and random pixels,", word_count,
             word_count);
    $display("with random stalls on both sides, a long output hold and a full drain.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches seen", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
